// ----- rtl/core/mwdm_pkg.sv -----
// Package for the masked 3x3 depth median block: field widths, codes,
// reset values and the structs passed between the top level and its units.
// Depends on nothing.
`default_nettype none

package mwdm_pkg;

    localparam int DEPTH_W    = 16;
    localparam int KEY_W      = DEPTH_W + 1;
    localparam int MED_W      = 17;
    localparam int CNT_W      = 4;
    localparam int POS_W      = 12;
    localparam int OFS_W      = POS_W + 1;
    localparam int FW_W       = 10;
    localparam int FH_W       = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int NBR_NUM    = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 10'd640;
    localparam logic [FH_W-1:0] FH_RESET = 9'd480;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // A key with the top bit set sorts above every real sample.
    localparam logic [KEY_W-1:0] KEY_EMPTY = {1'b1, {DEPTH_W{1'b0}}};

    typedef struct packed {
        logic vld;
        logic in_frame;
    } t_addr_flags;

    typedef struct packed {
        logic clr;
        logic push;
        logic start;
    } t_sel_ctrl;

    typedef struct packed {
        logic done;
        logic found;
    } t_sel_status;

endpackage

`default_nettype wire

// ----- rtl/core/masked_window_depth_median_top.sv -----
// Top level of the masked 3x3 depth median block: input and output stream
// channels, configuration registers, pixel store and sequencer.
// Depends on mwdm_pkg, mwdm_addr and mwdm_select.
//
// Usage. The slave channel carries items: tuser = 0 writes depth_mm at
// (pos_x, pos_y), tuser = 1 asks for the masked median of the 3x3
// neighbourhood around (pos_x, pos_y). A write outside the active frame is
// dropped. A query produces exactly one item on the master channel; a write
// produces none. Neighbours outside the frame and zero samples are ignored,
// and the median (mean of the two middle values for an even count) is given
// in half millimetres together with the count used and a found flag.
// Operation. The block takes one item at a time. A write passes through the
// address unit into the store. A query issues nine neighbour reads through
// the address unit and the one-port pixel store, runs the shared comparator
// over the n valid neighbours (skipped when n is zero), then finishes, loads
// the output register and returns to idle.
// Reset. The configuration returns to a 640 x 480 frame and all control
// state clears; the pixel store keeps no reset and must be written before
// it is read. Stalls. The result sits in an output register; a new item is
// taken while it waits, and only a finished query waits for that register.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_wdata; the user
// writes it only while idle, which the block itself does not enforce.
`default_nettype none

module masked_window_depth_median_top #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port.
    input  wire logic                                i_cfg_we,
    input  wire logic [mwdm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [mwdm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Input item channel.
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [39:0]                         i_s_tdata,  // pos_x, pos_y, depth_mm
    input  wire logic                                i_s_tuser,  // kind
    // Result item channel.
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [23:0]                              o_m_tdata,  // median_half_mm, valid_count, pad
    output logic                                     o_m_tuser   // found
);
    import mwdm_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WADDR  = 3'd1;
    localparam logic [2:0] S_WMEM   = 3'd2;
    localparam logic [2:0] S_GATHER = 3'd3;
    localparam logic [2:0] S_SELECT = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // Issue counter: nine neighbour issues, then the pipeline drains.
    localparam logic [3:0] K_ISSUE_END = 4'(NBR_NUM);
    localparam logic [3:0] K_START     = 4'(NBR_NUM + 2);

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [FW_W-1:0]          r_fw;
    logic [FH_W-1:0]          r_fh;
    logic [POS_W-1:0]         r_cx;
    logic [POS_W-1:0]         r_cy;
    logic [DEPTH_W-1:0]       r_depth;
    logic [1:0]               r_col;
    logic [1:0]               r_row;
    logic [3:0]               r_k;

    logic [DEPTH_W-1:0]       r_mem [0:DEPTH-1];
    logic [DEPTH_W-1:0]       r_rd_data;
    logic                     r_rd_inf;
    logic                     r_rd_vld;

    logic                     r_out_vld;
    logic [MED_W-1:0]         r_out_med;
    logic [CNT_W-1:0]         r_out_cnt;
    logic                     r_out_found;

    logic                     w_acc;
    logic                     w_issue;
    logic                     w_go;
    logic signed [OFS_W-1:0]  w_x;
    logic signed [OFS_W-1:0]  w_y;
    t_addr_flags              w_aflags;
    logic [ADDR_W-1:0]        w_aaddr;
    logic                     w_mem_we;
    t_sel_ctrl                w_sctrl;
    t_sel_status              w_sstat;
    logic [KEY_W-1:0]         w_key;
    logic [MED_W-1:0]         w_smed;
    logic [CNT_W-1:0]         w_scnt;
    logic                     w_out_free;
    logic                     w_out_load;

    assign o_s_tready = r_state == S_IDLE;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_issue    = (r_state == S_GATHER) && (r_k < K_ISSUE_END);
    assign w_go       = (r_state == S_WADDR) || w_issue;

    // Neighbour position is centre plus (col-1, row-1); a write uses the centre.
    assign w_x = $signed({r_cx[POS_W-1], r_cx}) + $signed({{(OFS_W-2){1'b0}}, r_col})
               - $signed(OFS_W'(1));
    assign w_y = $signed({r_cy[POS_W-1], r_cy}) + $signed({{(OFS_W-2){1'b0}}, r_row})
               - $signed(OFS_W'(1));

    mwdm_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_fw    (r_fw),
        .i_fh    (r_fh),
        .o_flags (w_aflags),
        .o_addr  (w_aaddr)
    );

    // Pixel store: one write or read port, read data registered.
    assign w_mem_we = (r_state == S_WMEM) && w_aflags.in_frame;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_aaddr] <= r_depth;
        end
        r_rd_data <= r_mem[w_aaddr];
        r_rd_inf  <= w_aflags.in_frame;
    end

    // Out-of-frame neighbours and zero samples enter the ring as empty keys.
    assign w_key = (r_rd_inf && (r_rd_data != '0)) ? {1'b0, r_rd_data} : KEY_EMPTY;

    assign w_sctrl.clr   = w_acc;
    assign w_sctrl.push  = r_rd_vld;
    assign w_sctrl.start = (r_state == S_GATHER) && (r_k == K_START);

    mwdm_select u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_sctrl),
        .i_key    (w_key),
        .o_stat   (w_sstat),
        .o_median (w_smed),
        .o_count  (w_scnt)
    );

    assign w_out_free = !r_out_vld || i_m_tready;
    assign w_out_load = (r_state == S_DONE) && w_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = (i_s_tuser == KIND_QUERY) ? S_GATHER : S_WADDR;
                end
            end
            S_WADDR:  n_state = S_WMEM;
            S_WMEM:   n_state = S_IDLE;
            S_GATHER: begin
                if (r_k == K_START) begin
                    n_state = S_SELECT;
                end
            end
            S_SELECT: begin
                if (w_sstat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fw      <= FW_RESET;
            r_fh      <= FH_RESET;
            r_col     <= '0;
            r_row     <= '0;
            r_k       <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_aflags.vld && (r_state == S_GATHER);
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FRAME_WIDTH) begin
                    r_fw <= i_cfg_wdata[FW_W-1:0];
                end
                if (i_cfg_idx == CFG_FRAME_HEIGHT) begin
                    r_fh <= i_cfg_wdata[FH_W-1:0];
                end
            end
            if (w_acc) begin
                r_k <= '0;
                if (i_s_tuser == KIND_QUERY) begin
                    r_col <= 2'd0;
                    r_row <= 2'd0;
                end else begin
                    r_col <= 2'd1;
                    r_row <= 2'd1;
                end
            end else if (r_state == S_GATHER) begin
                r_k <= r_k + 1'b1;
                if (w_issue) begin
                    if (r_col == 2'd2) begin
                        r_col <= 2'd0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cx    <= i_s_tdata[11:0];
            r_cy    <= i_s_tdata[23:12];
            r_depth <= i_s_tdata[39:24];
        end
        if (w_out_load) begin
            r_out_med   <= w_smed;
            r_out_cnt   <= w_scnt;
            r_out_found <= w_sstat.found;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_out_cnt, r_out_med};
    assign o_m_tuser  = r_out_found;

`ifndef ASSERT_OFF
    a_push_in_gather: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_GATHER))
        else $error("store read data pushed outside the gather phase");
    a_found_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tuser == (r_out_cnt != '0)) && (r_out_cnt <= 4'(NBR_NUM))))
        else $error("found flag or count inconsistent in result item");
    a_write_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_s_tuser == KIND_WRITE))
            |=> (r_state == S_WADDR) ##1 (r_state == S_WMEM) ##1 (r_state == S_IDLE))
        else $error("write item did not complete in three cycles");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/mwdm_addr.sv -----
// Neighbour address unit: bounds check against the active frame and the
// store, and the linear store address y*MAX_WIDTH+x, registered.
// Depends on mwdm_pkg.
`default_nettype none

module mwdm_addr #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480,
    parameter int ADDR_W     = 19
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_go,
    input  wire logic signed [mwdm_pkg::OFS_W-1:0]   i_x,
    input  wire logic signed [mwdm_pkg::OFS_W-1:0]   i_y,
    input  wire logic        [mwdm_pkg::FW_W-1:0]    i_fw,
    input  wire logic        [mwdm_pkg::FH_W-1:0]    i_fh,
    output mwdm_pkg::t_addr_flags                    o_flags,
    output logic             [ADDR_W-1:0]            o_addr
);
    import mwdm_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam logic signed [OFS_W-1:0] LIM_X = OFS_W'(MAX_WIDTH);
    localparam logic signed [OFS_W-1:0] LIM_Y = OFS_W'(MAX_HEIGHT);

    logic              w_inf;
    logic [ADDR_W-1:0] w_addr;
    t_addr_flags       r_flags;
    t_addr_flags       n_flags;
    logic [ADDR_W-1:0] r_addr;

    always_comb begin
        w_inf = !i_x[OFS_W-1] && !i_y[OFS_W-1]
             && (i_x < $signed({{(OFS_W-FW_W){1'b0}}, i_fw})) && (i_x < LIM_X)
             && (i_y < $signed({{(OFS_W-FH_W){1'b0}}, i_fh})) && (i_y < LIM_Y);
        w_addr = ADDR_W'(i_y[YW-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(i_x[XW-1:0]);
        n_flags.vld      = i_go;
        n_flags.in_frame = w_inf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= w_addr;
    end

    assign o_flags = r_flags;
    assign o_addr  = r_addr;

endmodule

`default_nettype wire

// ----- rtl/core/mwdm_select.sv -----
// Median selection: a nine-entry rotating ring and one shared comparator
// that extracts the smallest key per pass, stopping at the middle rank.
// Depends on mwdm_pkg.
`default_nettype none

module mwdm_select (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mwdm_pkg::t_sel_ctrl            i_ctrl,
    input  wire logic [mwdm_pkg::KEY_W-1:0]     i_key,
    output mwdm_pkg::t_sel_status               o_stat,
    output logic      [mwdm_pkg::MED_W-1:0]     o_median,
    output logic      [mwdm_pkg::CNT_W-1:0]     o_count
);
    import mwdm_pkg::*;

    logic [KEY_W-1:0]   r_ring [0:NBR_NUM-1];
    logic [KEY_W-1:0]   r_hold;
    logic [DEPTH_W-1:0] r_prev;
    logic [MED_W-1:0]   r_med;
    logic [CNT_W-1:0]   r_count;
    logic [2:0]         r_pass;
    logic [3:0]         r_step;
    logic               r_run;
    logic               r_done;

    logic               w_lt;
    logic [KEY_W-1:0]   n_hold;
    logic [KEY_W-1:0]   w_shout;
    logic [DEPTH_W-1:0] w_cur;
    logic [2:0]         w_mid;
    logic               w_last_step;
    logic               w_final;

    // One compare per cycle: the smaller key stays in the hold register,
    // the larger one goes back into the tail of the ring.
    always_comb begin
        w_lt        = r_ring[0] < r_hold;
        n_hold      = w_lt ? r_ring[0] : r_hold;
        w_shout     = w_lt ? r_hold : r_ring[0];
        w_cur       = n_hold[DEPTH_W-1:0];
        w_mid       = r_count[CNT_W-1:1];
        w_last_step = r_step == 4'(NBR_NUM - 1);
        w_final     = r_run && w_last_step && (r_pass == w_mid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
            r_pass  <= '0;
            r_step  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.clr) begin
                r_count <= '0;
            end
            if (i_ctrl.push && !i_key[KEY_W-1]) begin
                r_count <= r_count + 1'b1;
            end
            if (i_ctrl.start) begin
                r_step <= '0;
                r_pass <= '0;
                if (r_count == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                end
            end
            if (r_run) begin
                if (w_last_step) begin
                    r_step <= '0;
                    r_pass <= r_pass + 1'b1;
                    if (w_final) begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            for (int i = 0; i < NBR_NUM - 1; i++) begin
                r_ring[i] <= r_ring[i+1];
            end
            r_ring[NBR_NUM-1] <= i_key;
        end else if (r_run) begin
            for (int i = 0; i < NBR_NUM - 1; i++) begin
                r_ring[i] <= r_ring[i+1];
            end
            r_ring[NBR_NUM-1] <= w_shout;
        end
        if (i_ctrl.start) begin
            r_hold <= KEY_EMPTY;
            r_med  <= '0;
        end else if (r_run) begin
            if (w_last_step) begin
                r_hold <= KEY_EMPTY;
                r_prev <= w_cur;
            end else begin
                r_hold <= n_hold;
            end
            if (w_final) begin
                r_med <= r_count[0] ? {w_cur, 1'b0}
                                    : {1'b0, r_prev} + {1'b0, w_cur};
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.found = r_count != '0;
    assign o_median     = r_med;
    assign o_count      = r_count;

`ifndef ASSERT_OFF
    a_run_needs_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_count != '0))
        else $error("selection running with no valid samples");
    a_pass_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_pass <= w_mid))
        else $error("selection went past the middle rank");
    a_no_push_while_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> !i_ctrl.push)
        else $error("sample pushed while selection runs");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_masked_window_depth_median_top.sv -----
// Self-checking testbench for masked_window_depth_median_top: random pixel writes and
// 3x3 median queries over several frame sizes, checked against a behavioural predictor.
// Depends on mwdm_pkg and masked_window_depth_median_top.
`default_nettype none

module tb_masked_window_depth_median_top;
    import mwdm_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int FRAME_MAX_W    = 640;
    localparam int FRAME_MAX_H    = 480;
    localparam int STORE_SIZE     = FRAME_MAX_W * FRAME_MAX_H;
    localparam int SETTLE_CYCLES  = 70;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ITEMS    = 110;
    localparam int TIMEOUT_CYCLES = 4_000_000;

    typedef struct {
        logic        kind;
        bit   [11:0] pos_x;
        bit   [11:0] pos_y;
        bit   [15:0] depth_mm;
    } depth_item_t;

    typedef struct {
        bit [MED_W-1:0] median;
        bit [CNT_W-1:0] count;
        bit             found;
    } median_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tuser;

    // Predictor state: its own copy of the pixel store and of the frame registers.
    bit [15:0] depth_store [STORE_SIZE];
    bit        written_map [STORE_SIZE];
    int        cfg_width  = 640;
    int        cfg_height = 480;

    depth_item_t    pending_items [$];
    median_result_t expected_medians [$];
    depth_item_t    on_bus;
    int             gap_left = 0;
    int             stall_left = 0;
    int             mismatch_count = 0;
    bit             no_idle = 1'b0;
    int             ccx, ccy;

    masked_window_depth_median_top #(
        .MAX_WIDTH  (FRAME_MAX_W),
        .MAX_HEIGHT (FRAME_MAX_H)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),   // pos_x, pos_y, depth_mm
        .i_s_tuser   (s_tuser),   // kind
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),   // median_half_mm, valid_count, pad
        .o_m_tuser   (m_tuser)    // found
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // A pixel counts only inside the active frame, which is also clipped to the store.
    function automatic bit pix_in_frame(int x, int y);
        return x >= 0 && y >= 0 && x < cfg_width && x < FRAME_MAX_W &&
               y < cfg_height && y < FRAME_MAX_H;
    endfunction

    // Masked median of the 3x3 window, in half millimetres.
    function automatic median_result_t window_median(int cx, int cy);
        bit [15:0]      vals [9];
        bit [15:0]      key;
        int             n;
        int             i;
        int             j;
        int             x;
        int             y;
        median_result_t r;
        n = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                x = cx + dx;
                y = cy + dy;
                if (pix_in_frame(x, y) && depth_store[y * FRAME_MAX_W + x] != 16'd0) begin
                    vals[n] = depth_store[y * FRAME_MAX_W + x];
                    n++;
                end
            end
        end
        for (i = 1; i < n; i++) begin
            key = vals[i];
            j = i;
            while (j > 0 && vals[j - 1] > key) begin
                vals[j] = vals[j - 1];
                j--;
            end
            vals[j] = key;
        end
        r.median = '0;
        if (n > 0) begin
            if (n % 2 == 0)
                r.median = MED_W'(vals[n / 2 - 1]) + MED_W'(vals[n / 2]);
            else
                r.median = {vals[n / 2], 1'b0};
        end
        r.count = CNT_W'(n);
        r.found = (n > 0);
        return r;
    endfunction

    // Apply one accepted item to the predictor.
    task automatic record_item(depth_item_t it);
        int x;
        int y;
        x = $signed(it.pos_x);
        y = $signed(it.pos_y);
        if (it.kind == KIND_WRITE) begin
            if (pix_in_frame(x, y))
                depth_store[y * FRAME_MAX_W + x] = it.depth_mm;
        end else begin
            expected_medians.insert(expected_medians.size(), window_median(x, y));
        end
    endtask

    // Mostly no gap or a short one, now and then a long one.
    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit [15:0] random_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'd0;
        if (r < 22)
            return 16'hFFFF;
        if (r < 27)
            return 16'd1;
        if (r < 50)
            return 16'($urandom_range(1000, 1003));
        return 16'($urandom);
    endfunction

    function automatic int near_coord(int c);
        int off;
        off = $urandom_range(0, 6);
        return c + off - 3;
    endfunction

    function automatic int any_coord();
        bit [11:0] raw;
        raw = 12'($urandom);
        return $signed(raw);
    endfunction

    task automatic queue_write(int x, int y, bit [15:0] depth);
        depth_item_t it;
        it.kind     = KIND_WRITE;
        it.pos_x    = x[11:0];
        it.pos_y    = y[11:0];
        it.depth_mm = depth;
        pending_items.insert(pending_items.size(), it);
        if (pix_in_frame(x, y))
            written_map[y * FRAME_MAX_W + x] = 1'b1;
    endtask

    // A query never reads a store entry that was never written: any such
    // neighbour inside the frame is written first with a random sample.
    task automatic queue_query(int cx, int cy);
        depth_item_t it;
        int          x;
        int          y;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                x = cx + dx;
                y = cy + dy;
                if (pix_in_frame(x, y) && !written_map[y * FRAME_MAX_W + x])
                    queue_write(x, y, random_depth());
            end
        end
        it.kind     = KIND_QUERY;
        it.pos_x    = cx[11:0];
        it.pos_y    = cy[11:0];
        it.depth_mm = 16'($urandom);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic pick_cluster();
        int ew;
        int eh;
        ew = (cfg_width < FRAME_MAX_W) ? cfg_width : FRAME_MAX_W;
        eh = (cfg_height < FRAME_MAX_H) ? cfg_height : FRAME_MAX_H;
        case ($urandom_range(0, 2))
            0: ccx = 0;
            1: ccx = (ew > 0) ? ew - 1 : 0;
            default: ccx = (ew > 0) ? $urandom_range(0, ew - 1) : 0;
        endcase
        case ($urandom_range(0, 2))
            0: ccy = 0;
            1: ccy = (eh > 0) ? eh - 1 : 0;
            default: ccy = (eh > 0) ? $urandom_range(0, eh - 1) : 0;
        endcase
    endtask

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_result();
        median_result_t want;
        logic [16:0]    got_med;
        logic [3:0]     got_cnt;
        logic [2:0]     got_pad;
        got_med = m_tdata[16:0];
        got_cnt = m_tdata[20:17];
        got_pad = m_tdata[23:21];
        if (expected_medians.size() == 0) begin
            note_mismatch($sformatf("result with none waiting: tdata %h tuser %b",
                                    m_tdata, m_tuser));
            return;
        end
        want = expected_medians.pop_front();
        if (got_med !== want.median)
            note_mismatch($sformatf("median_half_mm expected %0d got %0d", want.median, got_med));
        if (got_cnt !== want.count)
            note_mismatch($sformatf("valid_count expected %0d got %0d", want.count, got_cnt));
        if (got_pad !== 3'd0)
            note_mismatch($sformatf("tdata padding expected 0 got %b", got_pad));
        if (m_tuser !== want.found)
            note_mismatch($sformatf("found expected %b got %b", want.found, m_tuser));
    endtask

    // Driver: presents queued items one by one with random gaps after each.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready)
                record_item(on_bus);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    on_bus = pending_items.pop_front();
                    s_tdata  <= {on_bus.depth_mm, on_bus.pos_y, on_bus.pos_x};
                    s_tuser  <= on_bus.kind;
                    s_tvalid <= 1'b1;
                    gap_left = idle_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result and stalls the master side at random.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                if ($urandom_range(0, 4) == 0)
                    stall_left = idle_gap();
                m_tready <= (stall_left == 0);
            end
        end
    end

    // Waits until every item is taken and every result has arrived, then lets
    // the block finish any write still in flight.
    task automatic settle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_medians.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            cfg_width = value[FW_W-1:0];
        else
            cfg_height = value[FH_W-1:0];
    endtask

    initial begin
        int          phase_w [PHASE_COUNT];
        int          phase_h [PHASE_COUNT];
        int          r;
        int          phase_step;
        bit [15:0]   block_vals [9];
        logic [FH_W-1:0] h9;

        phase_w = '{1, 0, 640, 1023, 3, 640, 2, 0, 640, 1, 0, 640};
        phase_h = '{1, 480, 0, 511, 3, 480, 7, 0, 1, 480, 0, 480};
        block_vals = '{16'd300, 16'd100, 16'd0, 16'd200, 16'd100, 16'hFFFF,
                       16'd7, 16'd1, 16'd5000};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);

        // Directed part under the reset frame of 640 x 480.
        // Top-left corner: two full-scale samples, one invalid zero and a one.
        queue_write(0, 0, 16'hFFFF);
        queue_write(1, 0, 16'hFFFF);
        queue_write(0, 1, 16'd0);
        queue_write(1, 1, 16'd1);
        queue_query(0, 0);
        // Centre outside the frame with only the corner pixel inside.
        queue_query(-1, -1);
        // Nothing inside the frame at all.
        queue_query(-5, -5);
        // Writes outside the frame are dropped.
        queue_write(640, 0, 16'd7);
        queue_write(0, 480, 16'd7);
        queue_write(-1, 2, 16'd7);
        queue_write(2047, -2048, 16'd7);
        // A full window with one zero gives an even count, then nine valid samples.
        for (int k = 0; k < 9; k++)
            queue_write(4 + k % 3, 4 + k / 3, block_vals[k]);
        queue_query(5, 5);
        queue_write(6, 4, 16'd42);
        queue_query(5, 5);
        queue_query(2047, 2047);
        queue_query(-2048, -2048);

        // Random phases, each under its own frame size; the sender drains fully
        // before every register write. A phase holds about PHASE_ITEMS items,
        // the writes that fill unwritten neighbours included.
        phase_w[7]  = $urandom_range(1, 640);
        phase_h[7]  = $urandom_range(1, 480);
        phase_w[10] = $urandom_range(0, 1023);
        phase_h[10] = $urandom_range(0, 511);
        for (int p = 0; p < PHASE_COUNT; p++) begin
            settle();
            no_idle = (p % 4 == 3);
            h9 = FH_W'(phase_h[p]);
            write_register(CFG_FRAME_WIDTH, CFG_DATA_W'(phase_w[p]));
            write_register(CFG_FRAME_HEIGHT, {1'($urandom_range(0, 1)), h9});
            repeat (3) @(posedge clk);
            @(negedge clk);
            phase_step = 0;
            while (pending_items.size() < PHASE_ITEMS) begin
                if (phase_step % 24 == 0)
                    pick_cluster();
                r = $urandom_range(0, 99);
                if (r < 40)
                    queue_query(near_coord(ccx), near_coord(ccy));
                else if (r < 80)
                    queue_write(near_coord(ccx), near_coord(ccy), random_depth());
                else if (r < 90)
                    queue_query(any_coord(), any_coord());
                else
                    queue_write(any_coord(), any_coord(), random_depth());
                phase_step++;
            end
        end

        settle();
        if (mismatch_count == 0 && expected_medians.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
